/* sv/hlr_pkg.sv */
// shared constants and control types for the histogram largest-rectangle block
// no dependencies; compiled first
package hlr_pkg;

   localparam int MAX_BARS_DEF    = 1024;
   localparam int HEIGHT_BITS_DEF = 16;
   localparam int AREA_BITS       = 26;

   // control from the sequencer to the area scoring unit
   typedef struct packed {
      logic mul_en;   // register height * width
      logic acc_en;   // fold registered product into the running max
      logic clear;    // drop the running max for the next histogram
   } score_ctl_type;

endpackage

/* sv/hlr_req_if.sv */
// input channel: one histogram bar per transfer
// depends on nothing; parameterized by the bar height width
interface hlr_req_if #(
   parameter int HEIGHT_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [HEIGHT_BITS-1:0] height;
   logic                   last;

   modport source (output valid, output height, output last, input ready);
   modport sink   (input valid, input height, input last, output ready);
endinterface

/* sv/hlr_rsp_if.sv */
// result channel: largest area and overflow flag, one transfer per histogram
// uses hlr_pkg for the area width
interface hlr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hlr_pkg::AREA_BITS-1:0] max_area;
   logic                          overflow;

   modport source (output valid, output max_area, output overflow, input ready);
   modport sink   (input valid, input max_area, input overflow, output ready);
endinterface

/* sv/hlr_stack_mem.sv */
// bar stack storage: one write port, one read port with registered read data
// entries are {left edge, height}; no reset, entries are undefined until pushed
module hlr_stack_mem #(
   parameter int ADDR_BITS  = 10,
   parameter int DATA_BITS  = 26
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/hlr_score.sv */
// area scoring: registered height * width product, then running maximum
// uses hlr_pkg for the control struct
module hlr_score #(
   parameter int HEIGHT_BITS = 16,
   parameter int WIDTH_BITS  = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hlr_pkg::score_ctl_type            ctl,
   input  logic [HEIGHT_BITS-1:0]            height,
   input  logic [WIDTH_BITS-1:0]             width,
   output logic [HEIGHT_BITS+WIDTH_BITS-1:0] best
);
   import hlr_pkg::*;

   localparam int PROD_BITS = HEIGHT_BITS + WIDTH_BITS;

   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] best_ff;
   logic [PROD_BITS-1:0] best_in;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= PROD_BITS'(height) * PROD_BITS'(width);
      end
   end

   always_comb begin
      best_in = best_ff;
      if (ctl.clear) begin
         best_in = '0;
      end else if (ctl.acc_en && (prod_ff > best_ff)) begin
         best_in = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

endmodule

/* sv/histogram_largest_rectangle.sv */
// timing: a bar is compared and then pushed, with a pop and a writeback for each entry
//   it pops, and is dropped once past the bar limit; the last bar then pops the entries
//   left and loads the result, waiting while an earlier result is not yet taken; a new
//   bar is taken only in idle; each pop waits on the registered stack read and multiply
// reset: synchronous, clears depth, bar count, running max and overflow; stack
//   memory contents are not cleared and only entries below the depth are used
module histogram_largest_rectangle #(
   parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
   parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   hlr_req_if.sink  req,
   hlr_rsp_if.source rsp
);
   import hlr_pkg::*;

   localparam int IDX_BITS   = $clog2(MAX_BARS);
   localparam int CNT_BITS   = $clog2(MAX_BARS + 1);
   localparam int ENTRY_BITS = IDX_BITS + HEIGHT_BITS;
   localparam int PROD_BITS  = HEIGHT_BITS + CNT_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMP   = 3'd1;
   localparam logic [2:0] ST_POP   = 3'd2;
   localparam logic [2:0] ST_FLUSH = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]             state_ff,   state_in;
   logic [CNT_BITS-1:0]    depth_ff,   depth_in;
   logic [CNT_BITS-1:0]    count_ff,   count_in;
   logic                   ovf_ff,     ovf_in;
   logic [HEIGHT_BITS-1:0] h_ff,       h_in;
   logic                   last_ff,    last_in;
   logic                   popped_ff,  popped_in;
   logic [IDX_BITS-1:0]    left_ff,    left_in;
   logic                   ret_ff,     ret_in;
   logic [IDX_BITS-1:0]    top_left_ff,   top_left_in;
   logic [HEIGHT_BITS-1:0] top_height_ff, top_height_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   logic [AREA_BITS-1:0]   rsp_area_ff,   rsp_area_in;
   logic                   rsp_ovf_ff,    rsp_ovf_in;

   logic                   req_xfer;
   logic                   pop_go;
   logic                   push_go;
   logic [CNT_BITS-1:0]    below_addr;
   logic [IDX_BITS-1:0]    push_left;
   logic [ENTRY_BITS-1:0]  rd_data;
   logic [CNT_BITS-1:0]    pop_width;
   logic [PROD_BITS-1:0]   best;
   score_ctl_type          score_ctl;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && (state_ff == ST_IDLE);

   // new top after a pop sits two below the current depth
   assign below_addr = depth_ff - CNT_BITS'(2);
   assign pop_width  = count_ff - CNT_BITS'(top_left_ff);
   // left edge of a pushed bar reaches back to the last entry it popped
   assign push_left  = popped_ff ? left_ff : count_ff[IDX_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      h_in          = h_ff;
      last_in       = last_ff;
      popped_in     = popped_ff;
      left_in       = left_ff;
      ret_in        = ret_ff;
      top_left_in   = top_left_ff;
      top_height_in = top_height_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_area_in   = rsp_area_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      pop_go        = 1'b0;
      push_go       = 1'b0;
      score_ctl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               h_in      = req.height;
               last_in   = req.last;
               popped_in = 1'b0;
               if (count_ff >= CNT_BITS'(MAX_BARS)) begin
                  ovf_in   = 1'b1;
                  state_in = req.last ? ST_FLUSH : ST_IDLE;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if ((depth_ff != '0) && (top_height_ff > h_ff)) begin
               pop_go    = 1'b1;
               ret_in    = 1'b0;
               popped_in = 1'b1;
               left_in   = top_left_ff;
               state_in  = ST_POP;
            end else begin
               push_go       = 1'b1;
               top_left_in   = push_left;
               top_height_in = h_ff;
               depth_in      = depth_ff + CNT_BITS'(1);
               count_in      = count_ff + CNT_BITS'(1);
               state_in      = last_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_POP: begin
            top_left_in      = rd_data[ENTRY_BITS-1:HEIGHT_BITS];
            top_height_in    = rd_data[HEIGHT_BITS-1:0];
            score_ctl.acc_en = 1'b1;
            state_in         = ret_ff ? ST_FLUSH : ST_CMP;
         end
         ST_FLUSH: begin
            if (depth_ff != '0) begin
               pop_go   = 1'b1;
               ret_in   = 1'b1;
               state_in = ST_POP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_area_in     = ovf_ff ? '0 : AREA_BITS'(best);
               rsp_ovf_in      = ovf_ff;
               score_ctl.clear = 1'b1;
               depth_in        = '0;
               count_in        = '0;
               ovf_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pop_go) begin
         score_ctl.mul_en = 1'b1;
         depth_in         = depth_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff          <= h_in;
      last_ff       <= last_in;
      popped_ff     <= popped_in;
      left_ff       <= left_in;
      ret_ff        <= ret_in;
      top_left_ff   <= top_left_in;
      top_height_ff <= top_height_in;
      rsp_area_ff   <= rsp_area_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   hlr_stack_mem #(
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (ENTRY_BITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push_go),
      .wr_addr (depth_ff[IDX_BITS-1:0]),
      .wr_data ({push_left, h_ff}),
      .rd_en   (pop_go),
      .rd_addr (below_addr[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   hlr_score #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .WIDTH_BITS  (CNT_BITS)
   ) u_score (
      .clock  (clock),
      .reset  (reset),
      .ctl    (score_ctl),
      .height (top_height_ff),
      .width  (pop_width),
      .best   (best)
   );

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.max_area = rsp_area_ff;
   assign rsp.overflow = rsp_ovf_ff;

   a_depth_le_count: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= count_ff)
      else $error("stack depth exceeds bar count");

   a_pop_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> $past(pop_go))
      else $error("pop writeback without a pop issue");

   a_ovf_zero_area: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_area_ff == '0))
      else $error("overflow result carries a nonzero area");

   a_push_below_max: assert property (@(posedge clock) disable iff (reset)
      push_go |-> (depth_ff < CNT_BITS'(MAX_BARS)))
      else $error("push into a full stack");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (state_in == ST_IDLE)) |=>
         ((depth_ff == '0) && (count_ff == '0) && !ovf_ff))
      else $error("state not cleared after a result");

endmodule
